[hdl/sst_pkg.sv]
package sst_pkg;

    localparam int MAX_MIPS_DEF   = 16;
    localparam int MAX_LAYERS_DEF = 64;
    localparam int STATE_BITS_DEF = 4;

    // Generation tag kept with each table entry; a whole-image set bumps it.
    localparam int EPOCH_BITS = 4;

    localparam int CFG_ADDR_W = 4;
    localparam int CFG_DATA_W = 32;

    localparam logic [1:0] REG_MIP_COUNT   = 2'd0;
    localparam logic [1:0] REG_LAYER_COUNT = 2'd1;
    localparam logic [1:0] REG_HAS_STENCIL = 2'd2;

    localparam logic [1:0] CMD_SET     = 2'd0;
    localparam logic [1:0] CMD_QUERY   = 2'd1;
    localparam logic [1:0] CMD_STENCIL = 2'd2;

    typedef struct packed {
        logic [4:0] mip_count;
        logic [6:0] layer_count;
        logic       has_stencil;
    } t_cfg;

endpackage

[hdl/subresource_state_tracker.sv]
// A command is accepted when i_start is high and o_busy low. A range command walks the N
// entries of its clamped range, one table entry per cycle through the single RAM port, and
// a query then passes a drain state; other commands finish in the prepare state.
// o_busy drops in the o_done cycle, so a new command can follow then; results cannot stall.
// After reset a pass clears all MAX_MIPS * MAX_LAYERS entries with o_busy high; the
// same pass follows every 2**EPOCH_BITS-th whole-image set, before its o_done beat.
module subresource_state_tracker #(
    parameter int MAX_MIPS   = sst_pkg::MAX_MIPS_DEF,
    parameter int MAX_LAYERS = sst_pkg::MAX_LAYERS_DEF,
    parameter int STATE_BITS = sst_pkg::STATE_BITS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_start,
    output logic                           o_busy,
    input  logic [1:0]                     i_cmd,
    input  logic [7:0]                     i_base_mip,
    input  logic [7:0]                     i_num_mips,
    input  logic [15:0]                    i_base_layer,
    input  logic [15:0]                    i_num_layers,
    input  logic [3:0]                     i_new_state,
    output logic                           o_done,
    output logic [3:0]                     o_range_state,
    output logic [3:0]                     o_whole_state,
    output logic [3:0]                     o_stencil_state,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [sst_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [sst_pkg::CFG_DATA_W-1:0] pwdata,
    output logic [sst_pkg::CFG_DATA_W-1:0] prdata,
    output logic                           pready
);
    import sst_pkg::*;

    localparam int TABLE_SIZE = MAX_MIPS * MAX_LAYERS;
    localparam int AW         = (TABLE_SIZE > 1) ? $clog2(TABLE_SIZE) : 1;
    localparam int MCW        = $clog2(MAX_MIPS + 1);
    localparam int LCW        = $clog2(MAX_LAYERS + 1);
    localparam int WORD_W     = 1 + EPOCH_BITS + STATE_BITS;

    localparam logic [2:0] S_SWEEP = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_PREP  = 3'd2;
    localparam logic [2:0] S_WALK  = 3'd3;
    localparam logic [2:0] S_DRAIN = 3'd4;

    t_cfg cfg;

    logic [2:0]            r_state, n_state;
    logic [1:0]            r_cmd, n_cmd;
    logic [7:0]            r_bm, n_bm;
    logic [7:0]            r_nm, n_nm;
    logic [15:0]           r_bl, n_bl;
    logic [15:0]           r_nl, n_nl;
    logic [3:0]            r_ns4, n_ns4;
    logic [STATE_BITS-1:0] r_base, n_base;
    logic [STATE_BITS-1:0] r_stencil, n_stencil;
    logic [EPOCH_BITS-1:0] r_epoch, n_epoch;
    logic [AW-1:0]         r_sweep, n_sweep;
    logic                  r_pend, n_pend;
    logic [MCW-1:0]        r_m, n_m;
    logic [MCW-1:0]        r_mend, n_mend;
    logic [LCW-1:0]        r_l, n_l;
    logic [LCW-1:0]        r_lbase, n_lbase;
    logic [LCW-1:0]        r_lend, n_lend;
    logic                  r_first, n_first;
    logic                  r_div, n_div;
    logic [STATE_BITS-1:0] r_range, n_range;
    logic                  r_rd_vld, n_rd_vld;
    logic                  r_done, n_done;
    logic [STATE_BITS-1:0] r_out_range, n_out_range;

    logic                  ram_we;
    logic [AW-1:0]         ram_addr;
    logic [WORD_W-1:0]     ram_wdata;
    logic [WORD_W-1:0]     ram_rdata;

    logic [STATE_BITS+3:0] ns_wide;
    logic [STATE_BITS-1:0] ns_s;
    logic [31:0]           mc32, lc32, mend32, lend32, msum32, lsum32, bm32, bl32;
    logic                  full, empty;
    logic [31:0]           walk_addr32;
    logic                  last_l, last_m;
    logic                  rd_valid;
    logic [EPOCH_BITS-1:0] rd_epoch;
    logic [STATE_BITS-1:0] rd_value, found;
    logic                  acc_first, acc_div;
    logic [STATE_BITS-1:0] acc_range;
    logic [STATE_BITS+3:0] out_range_w, out_whole_w, out_stencil_w;

    sst_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    sst_ram #(
        .WIDTH (WORD_W),
        .DEPTH (TABLE_SIZE)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_addr  (ram_addr),
        .i_wdata (ram_wdata),
        .o_rdata (ram_rdata)
    );

    // State codes are held at STATE_BITS; the 4-bit ports are masked or zero-extended.
    assign ns_wide = {{STATE_BITS{1'b0}}, r_ns4};
    assign ns_s    = ns_wide[STATE_BITS-1:0];

    assign mc32   = (32'(cfg.mip_count) > 32'(MAX_MIPS)) ? 32'(MAX_MIPS) : 32'(cfg.mip_count);
    assign lc32   = (32'(cfg.layer_count) > 32'(MAX_LAYERS)) ? 32'(MAX_LAYERS)
                                                              : 32'(cfg.layer_count);
    assign bm32   = 32'(r_bm);
    assign bl32   = 32'(r_bl);
    assign msum32 = bm32 + 32'(r_nm);
    assign lsum32 = bl32 + 32'(r_nl);
    assign mend32 = (msum32 > mc32) ? mc32 : msum32;
    assign lend32 = (lsum32 > lc32) ? lc32 : lsum32;
    assign full   = (r_bm == 8'd0) && (32'(r_nm) >= mc32) && (r_bl == 16'd0)
                 && (32'(r_nl) >= lc32);
    assign empty  = (bm32 >= mend32) || (bl32 >= lend32);

    assign walk_addr32 = 32'(r_m) * MAX_LAYERS + 32'(r_l);
    assign last_l      = (r_l + LCW'(1)) == r_lend;
    assign last_m      = (r_m + MCW'(1)) == r_mend;

    // An entry counts as an override only if it was written in the current epoch.
    assign rd_valid = ram_rdata[WORD_W-1];
    assign rd_epoch = ram_rdata[STATE_BITS +: EPOCH_BITS];
    assign rd_value = ram_rdata[STATE_BITS-1:0];
    assign found    = (rd_valid && (rd_epoch == r_epoch)) ? rd_value : r_base;

    always_comb begin
        acc_first = r_first;
        acc_div   = r_div;
        acc_range = r_range;
        if (r_rd_vld) begin
            if (r_first) begin
                acc_first = 1'b0;
                acc_range = found;
            end else if (found != r_range) begin
                acc_div = 1'b1;
            end
        end
    end

    always_comb begin
        n_state     = r_state;
        n_cmd       = r_cmd;
        n_bm        = r_bm;
        n_nm        = r_nm;
        n_bl        = r_bl;
        n_nl        = r_nl;
        n_ns4       = r_ns4;
        n_base      = r_base;
        n_stencil   = r_stencil;
        n_epoch     = r_epoch;
        n_sweep     = r_sweep;
        n_pend      = r_pend;
        n_m         = r_m;
        n_mend      = r_mend;
        n_l         = r_l;
        n_lbase     = r_lbase;
        n_lend      = r_lend;
        n_first     = acc_first;
        n_div       = acc_div;
        n_range     = acc_range;
        n_rd_vld    = 1'b0;
        n_done      = 1'b0;
        n_out_range = r_out_range;
        ram_we      = 1'b0;
        ram_addr    = walk_addr32[AW-1:0];
        ram_wdata   = '0;

        unique case (r_state)
            S_SWEEP: begin
                ram_we   = 1'b1;
                ram_addr = r_sweep;
                n_sweep  = r_sweep + AW'(1);
                if (r_sweep == AW'(TABLE_SIZE - 1)) begin
                    n_sweep = '0;
                    n_state = S_IDLE;
                    if (r_pend) begin
                        n_pend      = 1'b0;
                        n_done      = 1'b1;
                        n_out_range = '0;
                    end
                end
            end
            S_IDLE: begin
                if (i_start) begin
                    n_cmd   = i_cmd;
                    n_bm    = i_base_mip;
                    n_nm    = i_num_mips;
                    n_bl    = i_base_layer;
                    n_nl    = i_num_layers;
                    n_ns4   = i_new_state;
                    n_state = S_PREP;
                end
            end
            S_PREP: begin
                n_done      = 1'b1;
                n_out_range = '0;
                n_state     = S_IDLE;
                case (r_cmd)
                    CMD_SET: begin
                        if (full) begin
                            n_base    = ns_s;
                            n_stencil = cfg.has_stencil ? ns_s : '0;
                            n_epoch   = r_epoch + EPOCH_BITS'(1);
                            // Epoch wrap: old tags would alias, so clear the table first.
                            if (r_epoch == {EPOCH_BITS{1'b1}}) begin
                                n_done  = 1'b0;
                                n_pend  = 1'b1;
                                n_state = S_SWEEP;
                            end
                        end else if (!empty) begin
                            n_done = 1'b0;
                        end
                    end
                    CMD_QUERY: begin
                        n_out_range = r_base;
                        if (!full && !empty) begin
                            n_done = 1'b0;
                        end
                    end
                    CMD_STENCIL: begin
                        n_stencil = cfg.has_stencil ? ns_s : '0;
                    end
                    default: ;
                endcase
                if (!full && !empty && ((r_cmd == CMD_SET) || (r_cmd == CMD_QUERY))) begin
                    n_m     = bm32[MCW-1:0];
                    n_mend  = mend32[MCW-1:0];
                    n_l     = bl32[LCW-1:0];
                    n_lbase = bl32[LCW-1:0];
                    n_lend  = lend32[LCW-1:0];
                    n_first = 1'b1;
                    n_div   = 1'b0;
                    n_state = S_WALK;
                end
            end
            S_WALK: begin
                if (r_cmd == CMD_SET) begin
                    ram_we = 1'b1;
                    // Setting an entry to the base state drops its override.
                    if (ns_s != r_base) begin
                        ram_wdata = {1'b1, r_epoch, ns_s};
                    end
                end else begin
                    n_rd_vld = 1'b1;
                end
                if (last_l) begin
                    n_l = r_lbase;
                    n_m = r_m + MCW'(1);
                    if (last_m) begin
                        if (r_cmd == CMD_SET) begin
                            n_done      = 1'b1;
                            n_out_range = '0;
                            n_state     = S_IDLE;
                        end else begin
                            n_state = S_DRAIN;
                        end
                    end
                end else begin
                    n_l = r_l + LCW'(1);
                end
            end
            S_DRAIN: begin
                n_done      = 1'b1;
                n_out_range = acc_div ? '0 : acc_range;
                n_state     = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_SWEEP;
            r_base    <= '0;
            r_stencil <= '0;
            r_epoch   <= '0;
            r_sweep   <= '0;
            r_pend    <= 1'b0;
            r_rd_vld  <= 1'b0;
            r_done    <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_base    <= n_base;
            r_stencil <= n_stencil;
            r_epoch   <= n_epoch;
            r_sweep   <= n_sweep;
            r_pend    <= n_pend;
            r_rd_vld  <= n_rd_vld;
            r_done    <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd       <= n_cmd;
        r_bm        <= n_bm;
        r_nm        <= n_nm;
        r_bl        <= n_bl;
        r_nl        <= n_nl;
        r_ns4       <= n_ns4;
        r_m         <= n_m;
        r_mend      <= n_mend;
        r_l         <= n_l;
        r_lbase     <= n_lbase;
        r_lend      <= n_lend;
        r_first     <= n_first;
        r_div       <= n_div;
        r_range     <= n_range;
        r_out_range <= n_out_range;
    end

    assign out_range_w   = {4'd0, r_out_range};
    assign out_whole_w   = {4'd0, r_base};
    assign out_stencil_w = {4'd0, r_stencil};

    assign o_busy          = (r_state != S_IDLE);
    assign o_done          = r_done;
    assign o_range_state   = out_range_w[3:0];
    assign o_whole_state   = out_whole_w[3:0];
    assign o_stencil_state = out_stencil_w[3:0];

endmodule

[hdl/sst_ram.sv]
module sst_ram #(
    parameter int WIDTH = 9,
    parameter int DEPTH = 1024
) (
    input  logic                                     i_clk,
    input  logic                                     i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_addr,
    input  logic [WIDTH-1:0]                         i_wdata,
    output logic [WIDTH-1:0]                         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

[hdl/sst_cfg.sv]
module sst_cfg (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [sst_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [sst_pkg::CFG_DATA_W-1:0] pwdata,
    output logic [sst_pkg::CFG_DATA_W-1:0] prdata,
    output logic                           pready,
    output sst_pkg::t_cfg                  o_cfg
);
    import sst_pkg::*;

    t_cfg       r_cfg;
    logic       wr_en;
    logic [1:0] reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[3:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.mip_count   <= 5'd1;
            r_cfg.layer_count <= 7'd1;
            r_cfg.has_stencil <= 1'b0;
        end else if (wr_en) begin
            case (reg_idx)
                REG_MIP_COUNT:   r_cfg.mip_count   <= pwdata[4:0];
                REG_LAYER_COUNT: r_cfg.layer_count <= pwdata[6:0];
                REG_HAS_STENCIL: r_cfg.has_stencil <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_MIP_COUNT:   prdata = {27'd0, r_cfg.mip_count};
            REG_LAYER_COUNT: prdata = {25'd0, r_cfg.layer_count};
            REG_HAS_STENCIL: prdata = {31'd0, r_cfg.has_stencil};
            default:         prdata = '0;
        endcase
    end

    assign o_cfg = r_cfg;

endmodule

[tb/subresource_state_tracker_test.sv]
`timescale 1ns / 1ps

module subresource_state_tracker_test;
    import sst_pkg::*;

    localparam int TRK_MIPS   = MAX_MIPS_DEF;
    localparam int TRK_LAYERS = MAX_LAYERS_DEF;
    localparam int TRK_SIZE   = TRK_MIPS * TRK_LAYERS;
    localparam int IDLE_LIMIT = 6000;
    localparam int SETTLE_CYCLES = 40;
    localparam int RANDOM_PHASES = 6;
    localparam int PHASE_ITEMS   = 225;
    localparam logic [1:0] CMD_NOP = 2'd3;

    typedef struct packed {
        logic [3:0] range_state;
        logic [3:0] whole_state;
        logic [3:0] stencil_state;
    } t_status;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_start;
    logic                  o_busy;
    logic [1:0]            i_cmd;
    logic [7:0]            i_base_mip;
    logic [7:0]            i_num_mips;
    logic [15:0]           i_base_layer;
    logic [15:0]           i_num_layers;
    logic [3:0]            i_new_state;
    logic                  o_done;
    logic [3:0]            o_range_state;
    logic [3:0]            o_whole_state;
    logic [3:0]            o_stencil_state;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [CFG_ADDR_W-1:0] paddr;
    logic [CFG_DATA_W-1:0] pwdata;
    logic [CFG_DATA_W-1:0] prdata;
    logic                  pready;

    // Shadow copy of the tracked image.
    logic [4:0] cfg_mips;
    logic [6:0] cfg_layers;
    logic       cfg_stencil;
    logic [3:0] img_base;
    logic [3:0] img_stencil;
    bit         ovr_valid [TRK_SIZE];
    logic [3:0] ovr_value [TRK_SIZE];

    t_status pending_status[$];
    int      errors;
    int      idle_cycles;
    int      burst_left;
    bit      start_on;

    subresource_state_tracker dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_start         (i_start),
        .o_busy          (o_busy),
        .i_cmd           (i_cmd),
        .i_base_mip      (i_base_mip),
        .i_num_mips      (i_num_mips),
        .i_base_layer    (i_base_layer),
        .i_num_layers    (i_num_layers),
        .i_new_state     (i_new_state),
        .o_done          (o_done),
        .o_range_state   (o_range_state),
        .o_whole_state   (o_whole_state),
        .o_stencil_state (o_stencil_state),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready)
    );

    initial i_clk = 1'b0;
    always #4 i_clk = ~i_clk;

    function automatic int unsigned active_mips();
        return (cfg_mips > TRK_MIPS) ? TRK_MIPS : cfg_mips;
    endfunction

    function automatic int unsigned active_layers();
        return (cfg_layers > TRK_LAYERS) ? TRK_LAYERS : cfg_layers;
    endfunction

    // Applies one command to the shadow image and returns the status beat it produces.
    task automatic track_command(input logic [1:0] cmd, input logic [7:0] bm,
                                 input logic [7:0] nm, input logic [15:0] bl,
                                 input logic [15:0] nl, input logic [3:0] ns,
                                 output t_status status);
        int unsigned mc, lc, mend, lend, m, l, idx;
        bit          whole, first, split;
        logic [3:0]  found, seen;
        mc = active_mips();
        lc = active_layers();
        whole = (bm == 0) && (nm >= mc) && (bl == 0) && (nl >= lc);
        // Range ends are summed at full width, so they never wrap.
        mend = int'(bm) + int'(nm);
        lend = int'(bl) + int'(nl);
        if (mend > mc) mend = mc;
        if (lend > lc) lend = lc;
        seen = 4'd0;
        case (cmd)
            CMD_SET: begin
                if (whole) begin
                    img_base = ns;
                    img_stencil = cfg_stencil ? ns : 4'd0;
                    foreach (ovr_valid[i]) ovr_valid[i] = 1'b0;
                end else begin
                    for (m = bm; m < mend; m++) begin
                        for (l = bl; l < lend; l++) begin
                            idx = m * TRK_LAYERS + l;
                            if (ns == img_base) begin
                                ovr_valid[idx] = 1'b0;
                            end else begin
                                ovr_valid[idx] = 1'b1;
                                ovr_value[idx] = ns;
                            end
                        end
                    end
                end
            end
            CMD_QUERY: begin
                seen = img_base;
                if (!whole) begin
                    first = 1'b1;
                    split = 1'b0;
                    for (m = bm; m < mend; m++) begin
                        for (l = bl; l < lend; l++) begin
                            idx = m * TRK_LAYERS + l;
                            found = ovr_valid[idx] ? ovr_value[idx] : img_base;
                            if (first) begin
                                seen = found;
                                first = 1'b0;
                            end else if (found != seen) begin
                                split = 1'b1;
                            end
                        end
                    end
                    if (split) seen = 4'd0;
                end
            end
            CMD_STENCIL: begin
                img_stencil = cfg_stencil ? ns : 4'd0;
            end
            default: begin
            end
        endcase
        status = '{range_state: seen, whole_state: img_base, stencil_state: img_stencil};
    endtask

    task automatic check_field(input string name, input logic [3:0] want, input logic [3:0] got);
        if (got !== want) begin
            errors++;
            $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
        end
    endtask

    always @(posedge i_clk) begin
        t_status want;
        if (i_rst_n === 1'b1 && o_done === 1'b1) begin
            if (pending_status.size() == 0) begin
                errors++;
                $display("%0t: unexpected result beat, expected none actual %0d/%0d/%0d",
                         $time, o_range_state, o_whole_state, o_stencil_state);
            end else begin
                want = pending_status.pop_front();
                check_field("range_state", want.range_state, o_range_state);
                check_field("whole_state", want.whole_state, o_whole_state);
                check_field("stencil_state", want.stencil_state, o_stencil_state);
            end
        end
    end

    // Ends the run when neither side moves a beat for too long.
    always @(posedge i_clk) begin
        if (i_rst_n !== 1'b1 || o_done === 1'b1 || (i_start === 1'b1 && o_busy === 1'b0)
                || (psel === 1'b1 && penable === 1'b1)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("%0t: watchdog expired", $time);
            $display("subresource_state_tracker_test: errors");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Holds off until the block is idle and every expected beat has arrived.
    task automatic wait_drain();
        if (start_on) begin
            i_start <= 1'b0;
            start_on = 1'b0;
        end
        do @(posedge i_clk); while (pending_status.size() != 0 || o_busy !== 1'b0);
    endtask

    task automatic send_command(input logic [1:0] cmd, input logic [7:0] bm,
                                input logic [7:0] nm, input logic [15:0] bl,
                                input logic [15:0] nl, input logic [3:0] ns);
        t_status status;
        int      gap;
        i_start      <= 1'b1;
        start_on      = 1'b1;
        i_cmd        <= cmd;
        i_base_mip   <= bm;
        i_num_mips   <= nm;
        i_base_layer <= bl;
        i_num_layers <= nl;
        i_new_state  <= ns;
        do @(posedge i_clk); while (o_busy !== 1'b0);
        track_command(cmd, bm, nm, bl, nl, ns, status);
        pending_status.push_back(status);
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 80)
                                                     : $urandom_range(0, 12);
            gap = ($urandom_range(0, 3) == 0) ? $urandom_range(5, 20) : $urandom_range(1, 4);
            i_start <= 1'b0;
            start_on = 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // Writes one register, then reads it back. Call only with the block idle.
    task automatic program_reg(input logic [1:0] reg_idx, input logic [31:0] value);
        logic [31:0] masked;
        case (reg_idx)
            REG_MIP_COUNT: begin
                masked = value & 32'h1f;
                cfg_mips = masked[4:0];
            end
            REG_LAYER_COUNT: begin
                masked = value & 32'h7f;
                cfg_layers = masked[6:0];
            end
            default: begin
                masked = value & 32'h1;
                cfg_stencil = masked[0];
            end
        endcase
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        paddr   <= {reg_idx, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        if (prdata !== masked) begin
            errors++;
            $display("%0t: register %0d readback, expected %0d actual %0d",
                     $time, reg_idx, masked, prdata);
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic set_image(input logic [31:0] mips, input logic [31:0] layers,
                             input logic [31:0] stencil);
        wait_drain();
        program_reg(REG_MIP_COUNT, mips);
        program_reg(REG_LAYER_COUNT, layers);
        program_reg(REG_HAS_STENCIL, stencil);
    endtask

    task automatic test_reset_state();
        send_command(CMD_QUERY, 8'd0, 8'd1, 16'd0, 16'd1, 4'd9);
    endtask

    task automatic test_ranges();
        set_image(4, 8, 1);
        send_command(CMD_SET, 8'd0, 8'd4, 16'd0, 16'd8, 4'd5);
        send_command(CMD_SET, 8'd1, 8'd1, 16'd2, 16'd1, 4'd7);
        send_command(CMD_QUERY, 8'd1, 8'd1, 16'd2, 16'd1, 4'd0);
        send_command(CMD_QUERY, 8'd1, 8'd1, 16'd0, 16'd8, 4'd0);
        // Writing the base state back removes the override.
        send_command(CMD_SET, 8'd1, 8'd1, 16'd2, 16'd1, 4'd5);
        send_command(CMD_QUERY, 8'd1, 8'd1, 16'd0, 16'd8, 4'd0);
        send_command(CMD_SET, 8'd0, 8'd2, 16'd6, 16'd255, 4'd15);
        send_command(CMD_QUERY, 8'd0, 8'd2, 16'd6, 16'hffff, 4'd0);
        // Entirely outside the image: the set is dropped, the query sees the base.
        send_command(CMD_SET, 8'hff, 8'hff, 16'hffff, 16'hffff, 4'd0);
        send_command(CMD_QUERY, 8'hff, 8'hff, 16'hffff, 16'hffff, 4'd15);
        send_command(CMD_QUERY, 8'd2, 8'd0, 16'd0, 16'd8, 4'd0);
        send_command(CMD_SET, 8'd3, 8'd1, 16'd7, 16'd1, 4'd3);
        send_command(CMD_QUERY, 8'd3, 8'd200, 16'd7, 16'd60000, 4'd0);
        send_command(CMD_STENCIL, 8'd0, 8'd0, 16'd0, 16'd0, 4'd12);
        send_command(CMD_NOP, 8'd1, 8'd1, 16'd1, 16'd1, 4'd9);
        set_image(4, 8, 0);
        send_command(CMD_STENCIL, 8'd0, 8'd0, 16'd0, 16'd0, 4'd12);
        send_command(CMD_SET, 8'd0, 8'hff, 16'd0, 16'hffff, 4'd0);
        send_command(CMD_QUERY, 8'd0, 8'd2, 16'd6, 16'd2, 4'd0);
    endtask

    task automatic test_zero_counts();
        // With a count of zero every range here is empty: sets are dropped, queries see the base.
        set_image(0, 5, 1);
        send_command(CMD_SET, 8'd3, 8'd1, 16'd2, 16'd1, 4'd6);
        send_command(CMD_QUERY, 8'd7, 8'd9, 16'd100, 16'd1, 4'd0);
        set_image(2, 0, 1);
        send_command(CMD_SET, 8'd1, 8'd0, 16'd4, 16'd0, 4'd11);
    endtask

    task automatic test_count_limits();
        // Counts above the table size act as the table size.
        set_image(31, 127, 1);
        send_command(CMD_SET, 8'd0, 8'd16, 16'd0, 16'd64, 4'd2);
        send_command(CMD_SET, 8'd0, 8'd16, 16'd1, 16'd63, 4'd4);
        send_command(CMD_QUERY, 8'd0, 8'd16, 16'd1, 16'd64, 4'd0);
        send_command(CMD_QUERY, 8'd1, 8'd15, 16'd0, 16'd64, 4'd0);
        // Overrides outlive a shrink of the counts.
        set_image(3, 1, 1);
        send_command(CMD_QUERY, 8'd1, 8'd1, 16'd0, 16'd1, 4'd0);
        set_image(3, 2, 1);
        send_command(CMD_QUERY, 8'd1, 8'd1, 16'd1, 16'd1, 4'd0);
    endtask

    task automatic send_random();
        logic [1:0]  cmd;
        logic [7:0]  bm, nm;
        logic [15:0] bl, nl;
        logic [3:0]  ns;
        int unsigned mc, lc, pick;
        mc = active_mips();
        lc = active_layers();
        pick = $urandom_range(0, 99);
        cmd = (pick < 45) ? CMD_SET : (pick < 88) ? CMD_QUERY :
              (pick < 97) ? CMD_STENCIL : CMD_NOP;
        pick = $urandom_range(0, 99);
        if (pick < 12) begin
            bm = 8'd0;
            bl = 16'd0;
            nm = 8'($urandom_range(0, 1) ? mc : $urandom_range(mc, 255));
            nl = 16'($urandom_range(0, 1) ? lc : $urandom_range(lc, 65535));
        end else if (pick < 17) begin
            bm = 8'($urandom);
            nm = 8'($urandom);
            bl = 16'($urandom);
            nl = 16'($urandom);
        end else if (pick < 21) begin
            // Wide ranges that walk a large part of the table.
            bm = 8'($urandom_range(0, mc));
            nm = 8'($urandom);
            bl = 16'($urandom_range(0, lc));
            nl = 16'($urandom);
        end else if (pick < 28) begin
            bm = 8'($urandom_range(0, mc));
            nm = 8'd1;
            bl = 16'($urandom_range(0, lc));
            nl = 16'd1;
        end else begin
            bm = 8'($urandom_range(0, mc));
            nm = 8'($urandom_range(0, 4));
            bl = 16'($urandom_range(0, lc + 1));
            nl = 16'($urandom_range(0, 8));
        end
        pick = $urandom_range(0, 9);
        ns = (pick < 4) ? img_base
                        : 4'((pick < 7) ? $urandom_range(1, 3) : $urandom_range(0, 15));
        send_command(cmd, bm, nm, bl, nl, ns);
    endtask

    task automatic test_random_traffic();
        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            case (phase)
                0: set_image(16, 64, 1);
                1: set_image(2, 3, 0);
                2: set_image($urandom_range(1, 16), $urandom_range(1, 64), $urandom_range(0, 1));
                3: set_image(31, 127, $urandom_range(0, 1));
                4: set_image($urandom_range(0, 31), $urandom_range(0, 127), 1);
                default: set_image(5, 9, 1);
            endcase
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                send_random();
                if (n % 90 == 89) wait_drain();
            end
        end
    endtask

    initial begin
        i_rst_n      <= 1'b0;
        i_start      <= 1'b0;
        i_cmd        <= CMD_SET;
        i_base_mip   <= '0;
        i_num_mips   <= '0;
        i_base_layer <= '0;
        i_num_layers <= '0;
        i_new_state  <= '0;
        psel         <= 1'b0;
        penable      <= 1'b0;
        pwrite       <= 1'b0;
        paddr        <= '0;
        pwdata       <= '0;
        errors        = 0;
        idle_cycles   = 0;
        burst_left    = 0;
        start_on      = 1'b0;
        cfg_mips      = 5'd1;
        cfg_layers    = 7'd1;
        cfg_stencil   = 1'b0;
        img_base      = 4'd0;
        img_stencil   = 4'd0;
        foreach (ovr_valid[i]) ovr_valid[i] = 1'b0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        // The block clears its table after reset before it takes a command.
        wait_drain();

        test_reset_state();
        test_ranges();
        test_zero_counts();
        test_count_limits();
        test_random_traffic();

        wait_drain();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (errors == 0) begin
            $display("subresource_state_tracker_test: clean");
        end else begin
            $display("subresource_state_tracker_test: errors");
        end
        $finish;
    end

endmodule
